// ===== rtl/core/udt_pkg.sv =====
// udt_pkg: shared types and constants for the per-id usage delta table
// used by udt_store, udt_ratio and per_id_usage_delta_table_top
package udt_pkg;

	localparam int ID_W       = 32;
	localparam int TIME_W     = 64;
	localparam int USAGE_W    = 14;
	localparam int COUNT_W    = 9;
	localparam int CMD_W      = 2;
	localparam int TABLE_ENTRIES_DEF = 256;

	localparam logic [USAGE_W-1:0] FULL_SCALE = 14'd10000;

	localparam logic [CMD_W-1:0] CMD_BEGIN = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_END   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP   = 2'd3;

	// one table slot as held in the data memory
	typedef struct packed {
		logic [TIME_W-1:0] tstamp;
		logic [ID_W-1:0]   ident;
	} slot_t;

	// write strobes from the sequencer to the slot store
	typedef struct packed {
		logic data_we;
		logic seen_we;
		logic seen_val;
	} wr_ctl_t;

endpackage

// ===== rtl/core/udt_store.sv =====
// udt_store: slot data memory and seen-mark memory, one read and one write each
// depends on udt_pkg
module udt_store #(
	parameter int ENTRIES = udt_pkg::TABLE_ENTRIES_DEF,
	localparam int AW = $clog2(ENTRIES)
) (
	input  logic            clk,
	input  logic [AW-1:0]   rd_addr,
	input  udt_pkg::wr_ctl_t wr_ctl,
	input  logic [AW-1:0]   data_wr_addr,
	input  udt_pkg::slot_t  data_wr,
	input  logic [AW-1:0]   seen_wr_addr,
	output udt_pkg::slot_t  data_rd,
	output logic            seen_rd
);

	udt_pkg::slot_t data_mem [ENTRIES];
	logic           seen_mem [ENTRIES];

	// slot data, registered read
	always_ff @(posedge clk) begin
		if (wr_ctl.data_we) begin
			data_mem[data_wr_addr] <= data_wr;
		end
		data_rd <= data_mem[rd_addr];
	end

	// seen marks, registered read
	always_ff @(posedge clk) begin
		if (wr_ctl.seen_we) begin
			seen_mem[seen_wr_addr] <= wr_ctl.seen_val;
		end
		seen_rd <= seen_mem[rd_addr];
	end

endmodule

// ===== rtl/core/udt_ratio.sv =====
// udt_ratio: floor(num * 10000 / den) for num < den, shift-add multiply then restoring divide
// depends on udt_pkg
module udt_ratio (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [udt_pkg::TIME_W-1:0]  num,
	input  logic [udt_pkg::TIME_W-1:0]  den,
	output logic                        busy,
	output logic                        done,
	output logic [udt_pkg::USAGE_W-1:0] quo
);

	localparam int PW = udt_pkg::TIME_W + udt_pkg::USAGE_W;
	localparam int SW = $clog2(udt_pkg::USAGE_W);

	typedef enum logic [1:0] {R_IDLE, R_MUL, R_DIV} rstate_t;

	rstate_t                       state_q;
	logic [SW-1:0]                 step_q;
	logic [udt_pkg::TIME_W-1:0]    num_q;
	logic [PW-1:0]                 acc_q;
	logic [PW-1:0]                 den_sh_q;
	logic [udt_pkg::USAGE_W-1:0]   quo_q;
	logic                          done_q;
	logic [PW-1:0]                 addend;
	logic                          ge;

	// multiplier bit picks the operand, divider compares against shifted den
	assign addend = udt_pkg::FULL_SCALE[step_q] ? {{udt_pkg::USAGE_W{1'b0}}, num_q} : '0;
	assign ge     = (acc_q >= den_sh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= R_IDLE;
			step_q   <= '0;
			done_q   <= 1'b0;
			num_q    <= '0;
			acc_q    <= '0;
			den_sh_q <= '0;
			quo_q    <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				R_IDLE: begin
					if (start) begin
						num_q    <= num;
						den_sh_q <= {1'b0, den, {(udt_pkg::USAGE_W-1){1'b0}}};
						acc_q    <= '0;
						step_q   <= SW'(udt_pkg::USAGE_W-1);
						state_q  <= R_MUL;
					end
				end
				R_MUL: begin
					acc_q <= {acc_q[PW-2:0], 1'b0} + addend;
					if (step_q == '0) begin
						step_q  <= SW'(udt_pkg::USAGE_W-1);
						state_q <= R_DIV;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				R_DIV: begin
					if (ge) begin
						acc_q <= acc_q - den_sh_q;
					end
					den_sh_q <= den_sh_q >> 1;
					quo_q    <= {quo_q[udt_pkg::USAGE_W-2:0], ge};
					if (step_q == '0) begin
						done_q  <= 1'b1;
						state_q <= R_IDLE;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	assign busy = (state_q != R_IDLE);
	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== rtl/core/per_id_usage_delta_table_top.sv =====
// per_id_usage_delta_table_top: sequencer for the per-id usage delta table
// depends on udt_pkg, udt_store, udt_ratio
//
// One item is worked at a time. A begin clears the seen marks of all live
// entries, one seen mark per cycle. An entry does a linear search through the
// slot memory (one slot per cycle, registered read), plus a division when a
// usage ratio must be worked out (14 multiply steps and 14 quotient bits in the
// ratio unit). An end makes a compaction pass over the live slots, one slot read
// and at most one slot write per cycle. A result sits in an output register, so
// the next item is taken while it waits.
module per_id_usage_delta_table_top #(
	parameter int TABLE_ENTRIES = udt_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [udt_pkg::CMD_W-1:0]   command,
	input  logic [udt_pkg::TIME_W-1:0]  system_time,
	input  logic [udt_pkg::ID_W-1:0]    ident,
	input  logic                        times_known,
	input  logic [udt_pkg::TIME_W-1:0]  process_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [udt_pkg::USAGE_W-1:0] usage_hundredths,
	output logic                        was_added,
	output logic                        slot_reused,
	output logic [udt_pkg::COUNT_W-1:0] entries_used
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_CLEAR, S_SEARCH, S_UPDATE, S_DIVIDE, S_COMPACT, S_DONE
	} state_t;

	state_t                       state_q;
	logic [CW-1:0]                live_q;
	logic [CW-1:0]                cnt_q;
	logic [CW-1:0]                wptr_q;
	logic [AW-1:0]                idx_s1;
	logic                         vld_s1;
	logic [AW-1:0]                idx_q;
	logic [udt_pkg::TIME_W-1:0]   prev_q;
	logic [udt_pkg::TIME_W-1:0]   last_total_q;
	logic [udt_pkg::TIME_W-1:0]   sys_delta_q;
	logic                         init_q;
	logic [udt_pkg::ID_W-1:0]     ident_q;
	logic                         tk_q;
	logic [udt_pkg::TIME_W-1:0]   proc_q;
	logic [udt_pkg::USAGE_W-1:0]  res_usage_q;
	logic                         res_added_q;
	logic                         res_reused_q;
	logic                         out_valid_q;
	logic [udt_pkg::USAGE_W-1:0]  usage_q;
	logic                         added_q;
	logic                         reused_q;
	logic [udt_pkg::COUNT_W-1:0]  used_q;

	udt_pkg::wr_ctl_t             wr_ctl;
	udt_pkg::slot_t               data_wr;
	udt_pkg::slot_t               data_rd;
	logic                         seen_rd;
	logic [AW-1:0]                data_wr_addr;
	logic [AW-1:0]                seen_wr_addr;
	logic                         in_beat;
	logic                         hit;
	logic                         scan_more;
	logic                         table_full;
	logic [udt_pkg::TIME_W-1:0]   delta;
	logic                         use_ratio;
	logic                         div_start;
	logic                         div_busy;
	logic                         div_done;
	logic [udt_pkg::USAGE_W-1:0]  div_quo;

	assign in_ready   = (state_q == S_IDLE);
	assign in_beat    = in_valid && in_ready;
	assign hit        = vld_s1 && (data_rd.ident == ident_q);
	assign scan_more  = (cnt_q < live_q);
	assign table_full = (live_q >= CW'(TABLE_ENTRIES));
	assign delta      = proc_q - prev_q;
	assign use_ratio  = tk_q && init_q && (sys_delta_q != '0) && (proc_q >= prev_q);
	assign div_start  = (state_q == S_UPDATE) && use_ratio && (delta < sys_delta_q);

	// memory write strobes and addresses
	always_comb begin
		wr_ctl       = '0;
		data_wr_addr = idx_q;
		seen_wr_addr = idx_q;
		data_wr      = data_rd;
		case (state_q)
			S_CLEAR: begin
				wr_ctl.seen_we  = scan_more;
				wr_ctl.seen_val = 1'b0;
				seen_wr_addr    = cnt_q[AW-1:0];
			end
			S_UPDATE: begin
				wr_ctl.data_we  = 1'b1;
				wr_ctl.seen_we  = 1'b1;
				wr_ctl.seen_val = 1'b1;
				data_wr.ident   = ident_q;
				data_wr.tstamp  = tk_q ? proc_q : prev_q;
			end
			S_COMPACT: begin
				wr_ctl.data_we  = vld_s1 && seen_rd;
				wr_ctl.seen_we  = vld_s1 && seen_rd;
				wr_ctl.seen_val = 1'b1;
				data_wr_addr    = wptr_q[AW-1:0];
				seen_wr_addr    = wptr_q[AW-1:0];
			end
			default: ;
		endcase
	end

	udt_store #(.ENTRIES(TABLE_ENTRIES)) u_store (
		.clk          (clk),
		.rd_addr      (cnt_q[AW-1:0]),
		.wr_ctl       (wr_ctl),
		.data_wr_addr (data_wr_addr),
		.data_wr      (data_wr),
		.seen_wr_addr (seen_wr_addr),
		.data_rd      (data_rd),
		.seen_rd      (seen_rd)
	);

	udt_ratio u_ratio (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (delta),
		.den    (sys_delta_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// sequencer, table state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			live_q       <= '0;
			cnt_q        <= '0;
			wptr_q       <= '0;
			idx_s1       <= '0;
			vld_s1       <= 1'b0;
			idx_q        <= '0;
			prev_q       <= '0;
			last_total_q <= '0;
			sys_delta_q  <= '0;
			init_q       <= 1'b0;
			ident_q      <= '0;
			tk_q         <= 1'b0;
			proc_q       <= '0;
			res_usage_q  <= '0;
			res_added_q  <= 1'b0;
			res_reused_q <= 1'b0;
			out_valid_q  <= 1'b0;
			usage_q      <= '0;
			added_q      <= 1'b0;
			reused_q     <= 1'b0;
			used_q       <= '0;
		end else begin
			// output register loaded from the done state, freed by a result beat
			if (state_q == S_DONE && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						ident_q      <= ident;
						tk_q         <= times_known;
						proc_q       <= process_time;
						cnt_q        <= '0;
						wptr_q       <= '0;
						vld_s1       <= 1'b0;
						prev_q       <= '0;
						res_usage_q  <= '0;
						res_added_q  <= 1'b0;
						res_reused_q <= 1'b0;
						case (command)
							udt_pkg::CMD_BEGIN: begin
								sys_delta_q  <= init_q ? (system_time - last_total_q) : '0;
								last_total_q <= system_time;
								state_q      <= S_CLEAR;
							end
							udt_pkg::CMD_ENTRY: begin
								state_q <= (ident != '0) ? S_SEARCH : S_DONE;
							end
							udt_pkg::CMD_END: state_q <= S_COMPACT;
							default: state_q <= S_DONE;
						endcase
					end
				end
				// one seen mark cleared per cycle
				S_CLEAR: begin
					if (scan_more) begin
						cnt_q <= cnt_q + 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				// one slot compared per cycle, its read issued in the cycle before
				S_SEARCH: begin
					if (hit) begin
						idx_q   <= idx_s1;
						prev_q  <= data_rd.tstamp;
						vld_s1  <= 1'b0;
						state_q <= S_UPDATE;
					end else if (!scan_more && !vld_s1) begin
						res_added_q <= 1'b1;
						prev_q      <= '0;
						if (table_full) begin
							idx_q        <= '0;
							res_reused_q <= 1'b1;
						end else begin
							idx_q  <= live_q[AW-1:0];
							live_q <= live_q + 1'b1;
						end
						state_q <= S_UPDATE;
					end else begin
						vld_s1 <= scan_more;
						idx_s1 <= cnt_q[AW-1:0];
						if (scan_more) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				// slot written back, usage decided
				S_UPDATE: begin
					if (div_start) begin
						state_q <= S_DIVIDE;
					end else begin
						res_usage_q <= use_ratio ? udt_pkg::FULL_SCALE : '0;
						state_q     <= S_DONE;
					end
				end
				S_DIVIDE: begin
					if (div_done) begin
						res_usage_q <= div_quo;
						state_q     <= S_DONE;
					end
				end
				// seen slots moved down in order
				S_COMPACT: begin
					if (vld_s1 && seen_rd) begin
						wptr_q <= wptr_q + 1'b1;
					end
					if (!scan_more && !vld_s1) begin
						live_q  <= wptr_q;
						init_q  <= 1'b1;
						state_q <= S_DONE;
					end else begin
						vld_s1 <= scan_more;
						if (scan_more) begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				// result beat loaded once the output register is free
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						usage_q     <= res_usage_q;
						added_q     <= res_added_q;
						reused_q    <= res_reused_q;
						used_q      <= udt_pkg::COUNT_W'(live_q);
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign usage_hundredths = usage_q;
	assign was_added        = added_q;
	assign slot_reused      = reused_q;
	assign entries_used     = used_q;

	// live count never exceeds the table
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(TABLE_ENTRIES))
		else $error("live count beyond table size");

	// compaction write pointer never passes the scan pointer
	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COMPACT) |-> (wptr_q <= cnt_q))
		else $error("compaction write pointer ahead of scan");

	// the ratio unit is only started when idle
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("ratio unit restarted while busy");

	// a result beat never carries usage above full scale
	a_usage_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (usage_hundredths <= udt_pkg::FULL_SCALE))
		else $error("usage above full scale");

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking bench for per_id_usage_delta_table_top
// depends on udt_pkg and the rtl of the table; holds its own usage predictor
`timescale 1ns / 100ps

// expected-result store and table predictor
class usage_board;
	typedef struct packed {
		logic [13:0] usage;
		logic        added;
		logic        reused;
		logic [8:0]  used;
	} usage_res_t;

	logic [31:0] tbl_id [256];
	logic [63:0] tbl_time [256];
	bit          tbl_seen [256];
	int unsigned live;
	logic [63:0] last_total;
	logic [63:0] sys_delta;
	bit          init_done;
	usage_res_t  pending[$];
	int          errors;
	int          checked;

	function new();
		live = 0;
		last_total = 0;
		sys_delta = 0;
		init_done = 0;
		errors = 0;
		checked = 0;
		foreach (tbl_seen[i]) tbl_seen[i] = 0;
	endfunction

	// apply one accepted beat to the predicted table and queue its result
	function void note_input(logic [1:0] cmd, logic [63:0] stime, logic [31:0] id,
			bit tk, logic [63:0] ptime);
		usage_res_t r;
		int idx;
		int w;
		bit found;
		logic [63:0] prev;
		logic [63:0] d;
		logic [127:0] prod;
		r = '0;
		if (cmd == udt_pkg::CMD_BEGIN) begin
			sys_delta = init_done ? stime - last_total : 64'd0;
			last_total = stime;
			foreach (tbl_seen[i]) tbl_seen[i] = 0;
		end else if (cmd == udt_pkg::CMD_ENTRY && id != 0) begin
			idx = 0;
			found = 0;
			for (int i = 0; i < live; i++)
				if (!found && tbl_id[i] == id) begin
					idx = i;
					found = 1;
				end
			if (!found) begin
				if (live >= 256) begin
					idx = 0;
					r.reused = 1;
				end else begin
					idx = live;
					live++;
				end
				tbl_id[idx] = id;
				tbl_time[idx] = 0;
				r.added = 1;
			end
			tbl_seen[idx] = 1;
			if (tk) begin
				prev = tbl_time[idx];
				tbl_time[idx] = ptime;
				if (init_done && sys_delta != 0 && ptime >= prev) begin
					d = ptime - prev;
					if (d >= sys_delta) r.usage = 14'd10000;
					else begin
						prod = {64'd0, d} * 128'd10000;
						r.usage = 14'(prod / {64'd0, sys_delta});
					end
				end
			end
		end else if (cmd == udt_pkg::CMD_END) begin
			w = 0;
			for (int i = 0; i < live; i++)
				if (tbl_seen[i]) begin
					tbl_id[w] = tbl_id[i];
					tbl_time[w] = tbl_time[i];
					tbl_seen[w] = 1;
					w++;
				end
			for (int i = w; i < 256; i++) tbl_seen[i] = 0;
			live = w;
			init_done = 1;
		end
		r.used = 9'(live);
		pending.push_back(r);
	endfunction

	function void report(string what, int got, int want);
		$display("mismatch %0s: got %0d want %0d (result %0d)", what, got, want, checked);
		errors++;
	endfunction

	// compare one accepted result beat with the oldest expectation
	function void check_result(logic [13:0] u, logic a, logic s, logic [8:0] n);
		usage_res_t e;
		if (pending.size() == 0) begin
			$display("unexpected result beat");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (u !== e.usage) report("usage_hundredths", u, e.usage);
		if (a !== e.added) report("was_added", a, e.added);
		if (s !== e.reused) report("slot_reused", s, e.reused);
		if (n !== e.used) report("entries_used", n, e.used);
		checked++;
	endfunction
endclass

module tb_top;
	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [63:0] system_time;
	logic [31:0] ident;
	logic        times_known;
	logic [63:0] process_time;
	logic        out_valid;
	logic        out_ready;
	logic [13:0] usage_hundredths;
	logic        was_added;
	logic        slot_reused;
	logic [8:0]  entries_used;

	usage_board board;
	bit          quiet;
	int          cycles;
	int          beats_in;
	logic [63:0] sys_clock;
	logic [63:0] proc_clock [64];

	per_id_usage_delta_table_top dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.command(command), .system_time(system_time), .ident(ident),
		.times_known(times_known), .process_time(process_time),
		.out_valid(out_valid), .out_ready(out_ready),
		.usage_hundredths(usage_hundredths), .was_added(was_added),
		.slot_reused(slot_reused), .entries_used(entries_used)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// sample beats at the rising edge
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			board.note_input(command, system_time, ident, times_known, process_time);
			beats_in++;
		end
		if (arst_n && out_valid && out_ready)
			board.check_result(usage_hundredths, was_added, slot_reused, entries_used);
	end

	// timeout watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("timeout after %0d cycles", cycles);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver stalls in bursts
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 15) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// send one beat, with an optional idle burst first; valid is left high on return
	task automatic send(logic [1:0] c, logic [63:0] st, logic [31:0] id, bit tk,
			logic [63:0] pt);
		if (!quiet && $urandom_range(0, 11) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command <= c;
		system_time <= st;
		ident <= id;
		times_known <= tk;
		process_time <= pt;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// drop valid and wait until every expected result has come
	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (board.pending.size() != 0) @(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// one well-formed sample over a pool of ids with monotonic counters
	task automatic sample_round(int pool, int cnt, int span);
		int k;
		sys_clock = sys_clock + 64'($urandom_range(1, span));
		send(udt_pkg::CMD_BEGIN, sys_clock, $urandom(), 1'($urandom()), rand64());
		for (int i = 0; i < cnt; i++) begin
			k = $urandom_range(0, pool - 1);
			case ($urandom_range(0, 19))
				0: send(udt_pkg::CMD_ENTRY, rand64(), 32'(k + 1), 1'b0, rand64());
				1: send(udt_pkg::CMD_ENTRY, rand64(), 32'(k + 1), 1'b1, rand64());
				2: send(udt_pkg::CMD_ENTRY, rand64(), 32'd0, 1'b1, rand64());
				3: send(udt_pkg::CMD_NOP, rand64(), $urandom(), 1'($urandom()), rand64());
				default: begin
					proc_clock[k] = proc_clock[k] + 64'($urandom_range(0, span + span / 4));
					send(udt_pkg::CMD_ENTRY, rand64(), 32'(k + 1), 1'b1, proc_clock[k]);
				end
			endcase
		end
		send(udt_pkg::CMD_END, rand64(), $urandom(), 1'($urandom()), rand64());
	endtask

	initial begin
		board = new();
		quiet = 0;
		cycles = 0;
		beats_in = 0;
		sys_clock = 0;
		foreach (proc_clock[i]) proc_clock[i] = 0;
		in_valid = 1'b0;
		command = '0;
		system_time = '0;
		ident = '0;
		times_known = 1'b0;
		process_time = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: uninitialized usage, extremes, zero id, unused command
		send(udt_pkg::CMD_BEGIN, '1, 32'd0, 1'b0, 64'd0);
		send(udt_pkg::CMD_ENTRY, '0, 32'hFFFF_FFFF, 1'b1, 64'd500);
		send(udt_pkg::CMD_ENTRY, '0, 32'd7, 1'b0, '1);
		send(udt_pkg::CMD_ENTRY, '1, 32'd0, 1'b1, '1);
		send(udt_pkg::CMD_NOP, '1, '1, 1'b1, '1);
		send(udt_pkg::CMD_END, '0, 32'd0, 1'b0, 64'd0);
		// system delta wraps around zero
		send(udt_pkg::CMD_BEGIN, 64'd999, 32'd0, 1'b0, 64'd0);
		send(udt_pkg::CMD_ENTRY, '0, 32'hFFFF_FFFF, 1'b1, 64'd800);
		send(udt_pkg::CMD_ENTRY, '0, 32'd7, 1'b1, 64'd3000);
		send(udt_pkg::CMD_ENTRY, '0, 32'd9, 1'b1, '1);
		send(udt_pkg::CMD_END, '0, 32'd0, 1'b0, 64'd0);
		// zero delta, backwards counter, huge counters, id 7 aged out
		send(udt_pkg::CMD_BEGIN, 64'd999, 32'd0, 1'b0, 64'd0);
		send(udt_pkg::CMD_ENTRY, '0, 32'd9, 1'b1, 64'd5);
		send(udt_pkg::CMD_END, '0, 32'd0, 1'b0, 64'd0);
		send(udt_pkg::CMD_BEGIN, '1, 32'd0, 1'b0, 64'd0);
		send(udt_pkg::CMD_ENTRY, '0, 32'd9, 1'b1, 64'd4);
		send(udt_pkg::CMD_ENTRY, '0, 32'hFFFF_FFFF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
		send(udt_pkg::CMD_ENTRY, '0, 32'h8000_0000, 1'b1, 64'h8000_0000_0000_0000);
		send(udt_pkg::CMD_END, '0, 32'd0, 1'b0, 64'd0);
		drain();

		// fill past 256 entries so slot 0 gets reused
		sys_clock = '1;
		send(udt_pkg::CMD_BEGIN, 64'd0, 32'd0, 1'b0, 64'd0);
		for (int i = 0; i < 260; i++)
			send(udt_pkg::CMD_ENTRY, '0, 32'(1000 + i), 1'($urandom()), rand64());
		send(udt_pkg::CMD_END, '0, 32'd0, 1'b0, 64'd0);
		// age the full table down to nothing
		send(udt_pkg::CMD_BEGIN, 64'd0, 32'd0, 1'b0, 64'd0);
		send(udt_pkg::CMD_END, '0, 32'd0, 1'b0, 64'd0);
		sys_clock = 0;
		drain();

		// random samples, mostly small id pools
		while (beats_in < 1900) begin
			if (beats_in > 1500) quiet = 1;
			if ($urandom_range(0, 9) == 0)
				sample_round(64, $urandom_range(1, 60), $urandom_range(1, 1000000));
			else
				sample_round($urandom_range(1, 12), $urandom_range(0, 15),
					$urandom_range(1, 5000));
			if ($urandom_range(0, 15) == 0) drain();
		end

		drain();
		repeat (600) @(negedge clk);
		$display("ran %0d input beats and checked %0d results", beats_in, board.checked);
		$display("covered begin/entry/end, aging, full-table reuse, clamping and zero cases");
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
